### design/rcw_pkg.sv
// Shared types and constants for the raycast wall column texel unit.
package rcw_pkg;

  localparam int unsigned SCREEN_HEIGHT_DEF = 512;

  localparam logic [23:0] CEILING_RESET = 24'h87CEEB;
  localparam logic [23:0] FLOOR_RESET   = 24'h451800;

  typedef enum logic [1:0] {
    CFG_CEILING_COLOR = 2'd0,
    CFG_FLOOR_COLOR   = 2'd1,
    CFG_WALL_SCALE    = 2'd2
  } rcw_cfg_e;

  typedef enum logic [1:0] {
    REGION_CEILING = 2'd0,
    REGION_WALL    = 2'd1,
    REGION_FLOOR   = 2'd2
  } rcw_region_e;

  typedef struct packed {
    logic [9:0]  column;
    logic [8:0]  row;
    logic [31:0] distance;
    logic [7:0]  tex_column;
    logic [8:0]  tex_height;
    logic [8:0]  tex_width;
    logic [1:0]  texture_id;
  } rcw_in_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic [8:0]  row_out;
    logic [1:0]  region;
    logic [23:0] color;
    logic [1:0]  texture_out;
    logic [15:0] texel_offset;
  } rcw_out_t;

endpackage

### design/raycast_wall_column_texel_unit.sv
// Raycast wall column texel unit: top level, fully pipelined per-pixel mapper.
//
// One pixel item enters on in_valid_i/in_ready_o and one result leaves on
// out_valid_o/out_ready_i per transfer. Configuration (ceiling color, floor
// color, wall scale) is written through cfg_we_i/cfg_idx_i/cfg_data_i.
// From input transfer to result valid a pixel passes input capture, the
// bit-per-stage wall height divider, one classify stage, one multiply stage,
// the texel row divider and one output stage; the two divider pipelines
// set the depth. Throughput is one pixel per cycle unless the receiver stalls.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is dropped or repeated. Reset clears all
// valid bits and loads the default colors and a wall scale of zero.
module raycast_wall_column_texel_unit
  import rcw_pkg::*;
#(
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rcw_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rcw_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned DIV1_STEPS = 48;
  localparam int unsigned DIV2_STEPS = 9;
  localparam logic [48:0] MID17 = 49'(SCREEN_HEIGHT / 2) << 17;
  localparam logic [48:0] BOT_MAX = 49'(SCREEN_HEIGHT - 1);

  typedef struct packed {
    logic        valid;
    rcw_in_t     px;
    logic [31:0] rem;
    logic [47:0] dq;
  } div1_t;

  typedef struct packed {
    logic        valid;
    rcw_in_t     px;
    rcw_region_e region;
    logic        ok;
    logic [48:0] num;
    logic [47:0] wh;
  } cls_t;

  typedef struct packed {
    logic        valid;
    rcw_in_t     px;
    rcw_region_e region;
    logic        ok;
    logic        clamp;
    logic [57:0] rem;
    logic [48:0] dv;
    logic [8:0]  q;
  } div2_t;

  logic [23:0] ceil_q, floor_q, scale_q;
  div1_t       d1_q [DIV1_STEPS+1];
  cls_t        cls_q, cls_d;
  div2_t       d2_q [DIV2_STEPS+1];
  div2_t       mul_d;
  rcw_out_t    out_q, out_d;
  logic        out_valid_q;
  logic        en;

  function automatic div1_t div1_step(div1_t s);
    div1_t       r;
    logic [32:0] part;
    logic [32:0] diff;
    logic        ge;
    r    = s;
    part = {s.rem, s.dq[47]};
    ge   = part >= {1'b0, s.px.distance};
    diff = part - {1'b0, s.px.distance};
    r.rem = ge ? diff[31:0] : part[31:0];
    r.dq  = {s.dq[46:0], ge};
    return r;
  endfunction

  function automatic div2_t div2_step(div2_t s, int unsigned sh);
    div2_t       r;
    logic [57:0] dsh;
    logic        ge;
    r   = s;
    dsh = {9'd0, s.dv} << sh;
    ge  = s.rem >= dsh;
    if (ge) begin
      r.rem = s.rem - dsh;
    end
    r.q = {s.q[7:0], ge};
    return r;
  endfunction

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q  <= CEILING_RESET;
      floor_q <= FLOOR_RESET;
      scale_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CEILING_COLOR: ceil_q  <= cfg_data_i;
        CFG_FLOOR_COLOR:   floor_q <= cfg_data_i;
        CFG_WALL_SCALE:    scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify: wall span, region and texel row numerator
  always_comb begin
    logic [47:0] wh;
    logic [48:0] wh49;
    logic [48:0] top;
    logic [48:0] bot;
    logic [48:0] row49;
    logic [48:0] pos;
    wh    = d1_q[DIV1_STEPS].dq;
    wh49  = {1'b0, wh};
    top   = (wh49 >= MID17) ? '0 : ((MID17 - wh49) >> 17);
    bot   = (MID17 + wh49) >> 17;
    if (bot > BOT_MAX) begin
      bot = BOT_MAX;
    end
    row49 = {40'd0, d1_q[DIV1_STEPS].px.row};
    pos   = (row49 << 17) + wh49;
    cls_d.valid = d1_q[DIV1_STEPS].valid;
    cls_d.px    = d1_q[DIV1_STEPS].px;
    cls_d.wh    = wh;
    cls_d.num   = pos - MID17;
    cls_d.ok    = (pos > MID17) && (wh != '0) && (d1_q[DIV1_STEPS].px.tex_height != '0);
    if (row49 < top) begin
      cls_d.region = REGION_CEILING;
    end else if (row49 > bot) begin
      cls_d.region = REGION_FLOOR;
    end else begin
      cls_d.region = REGION_WALL;
    end
  end

  // Multiply: numerator times texture height; quotient at or above tex_height clamps
  always_comb begin
    logic [48:0] dv;
    dv = {cls_q.wh, 1'b0};
    mul_d.valid  = cls_q.valid;
    mul_d.px     = cls_q.px;
    mul_d.region = cls_q.region;
    mul_d.ok     = cls_q.ok;
    mul_d.dv     = dv;
    mul_d.clamp  = cls_q.num >= dv;
    mul_d.rem    = {9'd0, cls_q.num} * {49'd0, cls_q.px.tex_height};
    mul_d.q      = '0;
  end

  // Output: texel offset and colors
  always_comb begin
    div2_t       s;
    logic [8:0]  ty;
    logic [17:0] prod;
    logic [17:0] sum;
    s = d2_q[DIV2_STEPS];
    if (!s.ok) begin
      ty = '0;
    end else if (s.clamp) begin
      ty = s.px.tex_height - 9'd1;
    end else begin
      ty = s.q;
    end
    prod = {9'd0, ty} * {9'd0, s.px.tex_width};
    sum  = prod + {10'd0, s.px.tex_column};
    out_d.column_out   = s.px.column;
    out_d.row_out      = s.px.row;
    out_d.region       = s.region;
    out_d.color        = '0;
    out_d.texture_out  = '0;
    out_d.texel_offset = '0;
    case (s.region)
      REGION_CEILING: out_d.color = ceil_q;
      REGION_FLOOR:   out_d.color = floor_q;
      REGION_WALL: begin
        out_d.texture_out  = s.px.texture_id;
        out_d.texel_offset = sum[15:0];
      end
      default: ;
    endcase
  end

  // Pipeline stages; valid bits travel with the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DIV1_STEPS; i++) begin
        d1_q[i] <= '0;
      end
      for (int i = 0; i <= DIV2_STEPS; i++) begin
        d2_q[i] <= '0;
      end
      cls_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      d1_q[0].valid <= in_valid_i;
      d1_q[0].px    <= in_data_i;
      d1_q[0].rem   <= '0;
      d1_q[0].dq    <= {scale_q, 24'd0};
      for (int i = 1; i <= DIV1_STEPS; i++) begin
        d1_q[i].valid <= d1_q[i-1].valid;
        d1_q[i].px    <= d1_q[i-1].px;
        d1_q[i].rem   <= div1_step(d1_q[i-1]).rem;
        d1_q[i].dq    <= div1_step(d1_q[i-1]).dq;
      end
      cls_q <= cls_d;
      d2_q[0] <= mul_d;
      for (int i = 1; i <= DIV2_STEPS; i++) begin
        d2_q[i].valid  <= d2_q[i-1].valid;
        d2_q[i].px     <= d2_q[i-1].px;
        d2_q[i].region <= d2_q[i-1].region;
        d2_q[i].ok     <= d2_q[i-1].ok;
        d2_q[i].clamp  <= d2_q[i-1].clamp;
        d2_q[i].dv     <= d2_q[i-1].dv;
        d2_q[i].rem    <= div2_step(d2_q[i-1], DIV2_STEPS - i).rem;
        d2_q[i].q      <= div2_step(d2_q[i-1], DIV2_STEPS - i).q;
      end
      out_q       <= out_d;
      out_valid_q <= d2_q[DIV2_STEPS].valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### dv/raycast_wall_column_texel_unit_tb.sv
// Testbench for the raycast wall column texel unit: directed and random pixels checked in order.
module raycast_wall_column_texel_unit_tb;
  import rcw_pkg::*;

  localparam int unsigned SCR_H = 512;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  rcw_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rcw_out_t    out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;

  logic [23:0] ceil_rgb;
  logic [23:0] floor_rgb;
  logic [23:0] scale_q8;

  rcw_out_t pixel_q[$];
  int unsigned mismatch_cnt;
  bit          rx_steady;

  raycast_wall_column_texel_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #50000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic rcw_out_t map_pixel(rcw_in_t px);
    rcw_out_t    res;
    logic [47:0] wh;
    logic [63:0] mid, top, bot, pos, num, ty;
    res = '0;
    if (px.distance == 0) wh = '1;
    else wh = 48'({24'd0, scale_q8, 24'd0} / {40'd0, px.distance});
    mid = 64'(SCR_H / 2) << 17;
    top = (64'(wh) >= mid) ? 64'd0 : ((mid - 64'(wh)) >> 17);
    bot = (mid + 64'(wh)) >> 17;
    if (bot > 64'(SCR_H - 1)) bot = 64'(SCR_H - 1);
    res.column_out = px.column;
    res.row_out    = px.row;
    if (64'(px.row) < top) begin
      res.region = REGION_CEILING;
      res.color  = ceil_rgb;
    end else if (64'(px.row) > bot) begin
      res.region = REGION_FLOOR;
      res.color  = floor_rgb;
    end else begin
      res.region      = REGION_WALL;
      res.texture_out = px.texture_id;
      pos = (64'(px.row) << 17) + 64'(wh);
      ty  = 0;
      if (pos > mid && wh != 0 && px.tex_height != 0) begin
        num = pos - mid;
        // 49-bit numerator times 9-bit height fits in 64 bits
        ty = (num * 64'(px.tex_height)) / (64'(wh) << 1);
        if (ty > 64'(px.tex_height) - 1) ty = 64'(px.tex_height) - 1;
      end
      res.texel_offset = 16'(ty * 64'(px.tex_width) + 64'(px.tex_column));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // result side: random stall unless rx_steady is set, checks each transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    rcw_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data_o.row_out), 32'd0);
        end else begin
          want = pixel_q.pop_front();
          if (out_data_o.column_out !== want.column_out)
            report_mismatch("column", 32'(out_data_o.column_out), 32'(want.column_out));
          if (out_data_o.row_out !== want.row_out)
            report_mismatch("row", 32'(out_data_o.row_out), 32'(want.row_out));
          if (out_data_o.region !== want.region)
            report_mismatch("region", 32'(out_data_o.region), 32'(want.region));
          if (out_data_o.color !== want.color)
            report_mismatch("color", 32'(out_data_o.color), 32'(want.color));
          if (out_data_o.texture_out !== want.texture_out)
            report_mismatch("texture", 32'(out_data_o.texture_out), 32'(want.texture_out));
          if (out_data_o.texel_offset !== want.texel_offset)
            report_mismatch("texel offset", 32'(out_data_o.texel_offset),
                            32'(want.texel_offset));
        end
      end
      out_ready_i <= rx_steady || ($urandom_range(99) >= 24);
    end
  end

  // valid stays up between back-to-back items; it drops only while idling or draining
  task automatic send_pixel(rcw_in_t px, bit steady);
    if (!steady) begin
      while ($urandom_range(99) < 24) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    pixel_q.push_back(map_pixel(px));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(rcw_cfg_e idx, logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_CEILING_COLOR: ceil_rgb  = val;
      CFG_FLOOR_COLOR:   floor_rgb = val;
      default:           scale_q8  = val;
    endcase
  endtask

  function automatic rcw_in_t make_pixel(logic [8:0] row, logic [31:0] dist_val,
                                         logic [8:0] th, logic [8:0] tw);
    rcw_in_t px;
    px.column     = 10'($urandom);
    px.row        = row;
    px.distance   = dist_val;
    px.tex_column = 8'($urandom);
    px.tex_height = th;
    px.tex_width  = tw;
    px.texture_id = 2'($urandom);
    return px;
  endfunction

  // random distance biased toward values that give walls of screen scale
  function automatic logic [31:0] pick_distance();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'($urandom);
      2:       return 32'hFFFF_FFFF - 32'($urandom_range(3));
      3:       return 32'($urandom_range(255));
      default: return 32'($urandom_range(32'h0010_0000, 32'h0000_4000));
    endcase
  endfunction

  function automatic logic [8:0] pick_size();
    case ($urandom_range(5))
      0:       return 9'd256;
      1:       return 9'($urandom_range(3, 0));
      2:       return 9'($urandom);
      default: return 9'($urandom_range(256, 1));
    endcase
  endfunction

  task automatic test_reset_defaults();
    ceil_rgb  = CEILING_RESET;
    floor_rgb = FLOOR_RESET;
    scale_q8  = '0;
    // zero scale: only the middle row is wall
    send_pixel(make_pixel(9'd0, 32'h0001_0000, 9'd64, 9'd64), 1'b0);
    send_pixel(make_pixel(9'(SCR_H / 2), 32'h0001_0000, 9'd64, 9'd64), 1'b0);
    send_pixel(make_pixel(9'd511, 32'h0001_0000, 9'd64, 9'd64), 1'b0);
    // zero distance saturates to a full-height wall
    send_pixel(make_pixel(9'd0, 32'd0, 9'd256, 9'd256), 1'b0);
    send_pixel(make_pixel(9'd511, 32'd0, 9'd256, 9'd256), 1'b0);
    wait_drained();
  endtask

  task automatic test_directed_extremes();
    write_reg(CFG_CEILING_COLOR, 24'hFFFFFF);
    write_reg(CFG_FLOOR_COLOR, 24'h000000);
    write_reg(CFG_WALL_SCALE, 24'h004000);
    send_pixel(make_pixel(9'd0, 32'h0001_0000, 9'd64, 9'd64), 1'b0);
    send_pixel(make_pixel(9'd511, 32'h0001_0000, 9'd64, 9'd64), 1'b0);
    send_pixel(make_pixel(9'd200, 32'h0001_0000, 9'd0, 9'd256), 1'b0);
    send_pixel(make_pixel(9'd256, 32'h0001_0000, 9'd256, 9'd256), 1'b0);
    send_pixel(make_pixel(9'd300, 32'h0001_0000, 9'd256, 9'd511), 1'b0);
    send_pixel(make_pixel(9'd511, 32'hFFFF_FFFF, 9'd511, 9'd511), 1'b0);
    send_pixel(make_pixel(9'd256, 32'hFFFF_FFFF, 9'd8, 9'd8), 1'b0);
    send_pixel(make_pixel(9'd255, 32'd0, 9'd1, 9'd1), 1'b0);
    wait_drained();
    write_reg(CFG_WALL_SCALE, 24'hFFFFFF);
    write_reg(CFG_CEILING_COLOR, 24'h000000);
    write_reg(CFG_FLOOR_COLOR, 24'hFFFFFF);
    send_pixel(make_pixel(9'd0, 32'd1, 9'd256, 9'd256), 1'b0);
    send_pixel(make_pixel(9'd100, 32'h00FF_0000, 9'd128, 9'd200), 1'b0);
    send_pixel(make_pixel(9'd511, 32'hFFFF_FFFF, 9'd128, 9'd200), 1'b0);
    send_pixel(make_pixel(9'd10, 32'h0800_0000, 9'd64, 9'd64), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_pixels();
    logic [23:0] scales[4] = '{24'h000100, 24'h00C000, 24'h020000, 24'($urandom)};
    rcw_in_t px;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_WALL_SCALE, scales[ph]);
      write_reg(CFG_CEILING_COLOR, 24'($urandom));
      write_reg(CFG_FLOOR_COLOR, 24'($urandom));
      rx_steady = (ph == 2);
      for (int n = 0; n < 300; n++) begin
        px = make_pixel(9'($urandom), pick_distance(), pick_size(), pick_size());
        send_pixel(px, ph == 2);
        // sender pause until the pipeline empties
        if (n == 150) wait_drained();
      end
      wait_drained();
      rx_steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_CEILING_COLOR;
    cfg_data_i   = '0;
    mismatch_cnt = 0;
    rx_steady    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_pixels();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
